/* hw/rtl/epcm_pkg.sv */
package epcm_pkg;

  localparam logic [1:0] CMD_REG  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_MEM  = 2'd2;

  localparam logic [3:0] REG_ENV    = 4'd0;
  localparam logic [3:0] REG_PAN    = 4'd1;
  localparam logic [3:0] REG_FRQ_LO = 4'd2;
  localparam logic [3:0] REG_FRQ_HI = 4'd3;
  localparam logic [3:0] REG_LP_LO  = 4'd4;
  localparam logic [3:0] REG_LP_HI  = 4'd5;
  localparam logic [3:0] REG_START  = 4'd6;
  localparam logic [3:0] REG_CTRL   = 4'd7;
  localparam logic [3:0] REG_ENABLE = 4'd8;

  localparam logic CFG_RATE_STEP = 1'b0;
  localparam logic CFG_STEREO    = 1'b1;

  localparam logic [16:0] RATE_RESET = 17'd12098;
  localparam logic [7:0]  LOOP_MARK  = 8'hFF;
  localparam int          MAX_CH     = 8;
  localparam int          STEP_SHIFT = 14;
  localparam int          GAIN_SHIFT = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CH,
    ST_RD0,
    ST_RD1,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FIN_RD,
    ST_FIN_CHK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_ENTRY,
    RD_LOOP,
    RD_K,
    RD_POS
  } rd_sel_e;

  typedef struct packed {
    logic    clr;
    logic    ld_ch;
    logic    mix;
    logic    set_loop;
    logic    k_inc;
    logic    store_pos;
    logic    store_loop;
    logic    ch_inc;
    logic    out_ld;
    logic    rd_en;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic ch_on;
    logic mark;
    logic scan_more;
    logic last_ch;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/epcm_ram.sv */
module epcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/epcm_dp.sv */
module epcm_dp import epcm_pkg::*; #(
  parameter int FRAC_BITS      = 11,
  parameter int CHANNELS       = 8,
  parameter int WAVE_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [1:0]  in_cmd_i,
  input  logic [3:0]  reg_addr_i,
  input  logic [7:0]  reg_data_i,
  input  logic [15:0] mem_addr_i,
  input  logic [7:0]  mem_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [16:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] left_o,
  output logic [16:0] right_o
);

  localparam int A  = WAVE_ADDR_BITS;
  localparam int PW = WAVE_ADDR_BITS + FRAC_BITS;

  logic [16:0]   rate_q;
  logic          stereo_q;
  logic [7:0]    env_q [MAX_CH];
  logic [7:0]    pan_q [MAX_CH];
  logic [15:0]   frq_q [MAX_CH];
  logic [15:0]   lp_q  [MAX_CH];
  logic [7:0]    st_q  [MAX_CH];
  logic [PW-1:0] posa_q [MAX_CH];
  logic [7:0]    en_q;
  logic [2:0]    sel_q;
  logic [7:0]    ctl_q;
  logic [3:0]    bank_q;

  logic [2:0]    ch_q;
  logic [PW-1:0] pos_q;
  logic [18:0]   step_q;
  logic [5:0]    ml_q, mr_q;
  logic [A:0]    k_q;
  logic [A-1:0]  kend_q;
  logic signed [16:0] accl_q, accr_q;
  logic [16:0]   outl_q, outr_q;
  logic          oval_q;

  logic [7:0]    rdata;
  logic [A-1:0]  raddr;
  logic [PW-1:0] loop_pos, new_pos;
  logic [11:0]   gl_full, gr_full;
  logic [5:0]    gl, gr;
  logic [32:0]   step_full;
  logic [12:0]   pl, pr;
  logic signed [16:0] addl, addr_r;
  logic          reg_wr, mem_wr;

  assign reg_wr = take_i && (in_cmd_i == CMD_REG);
  assign mem_wr = take_i && (in_cmd_i == CMD_MEM);

  assign loop_pos = {lp_q[ch_q][A-1:0], {FRAC_BITS{1'b0}}};
  assign new_pos  = pos_q + PW'(step_q);

  // gains and step for the channel being loaded
  assign gl_full   = env_q[ch_q] * pan_q[ch_q][3:0];
  assign gr_full   = env_q[ch_q] * pan_q[ch_q][7:4];
  assign gl        = gl_full[GAIN_SHIFT +: 6];
  assign gr        = gr_full[GAIN_SHIFT +: 6];
  assign step_full = frq_q[ch_q] * rate_q;

  // sign-magnitude sample times gain
  assign pl     = rdata[6:0] * ml_q;
  assign pr     = rdata[6:0] * mr_q;
  assign addl   = rdata[7] ? -$signed({4'b0, pl}) : $signed({4'b0, pl});
  assign addr_r = rdata[7] ? -$signed({4'b0, pr}) : $signed({4'b0, pr});

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ENTRY: raddr = posa_q[ch_q][PW-1:FRAC_BITS];
      RD_LOOP:  raddr = lp_q[ch_q][A-1:0];
      RD_K:     raddr = k_q[A-1:0];
      RD_POS:   raddr = pos_q[PW-1:FRAC_BITS];
      default:  raddr = pos_q[PW-1:FRAC_BITS];
    endcase
  end

  epcm_ram #(.WIDTH(8), .DEPTH(1 << A)) u_wave (
    .clk_i   (clk_i),
    .we_i    (mem_wr),
    .waddr_i (mem_addr_i[A-1:0]),
    .wdata_i (mem_data_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.ch_on     = en_q[ch_q];
  assign sts_o.mark      = (rdata == LOOP_MARK);
  assign sts_o.scan_more = (k_q < {1'b0, kend_q});
  assign sts_o.last_ch   = (ch_q == 3'(CHANNELS - 1));
  assign sts_o.out_free  = !oval_q || out_ready_i;

  // config and register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RATE_RESET;
      stereo_q <= 1'b1;
      en_q     <= '0;
      sel_q    <= '0;
      ctl_q    <= '0;
      bank_q   <= '0;
      for (int c = 0; c < MAX_CH; c++) begin
        env_q[c]  <= '0;
        pan_q[c]  <= '0;
        frq_q[c]  <= '0;
        lp_q[c]   <= '0;
        st_q[c]   <= '0;
        posa_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_RATE_STEP: rate_q   <= cfg_data_i;
          CFG_STEREO:    stereo_q <= cfg_data_i[0];
          default:       ;
        endcase
      end
      if (reg_wr) begin
        if (reg_addr_i < REG_CTRL) begin
          if (32'(sel_q) < CHANNELS) begin
            case (reg_addr_i)
              REG_ENV:    env_q[sel_q]       <= reg_data_i;
              REG_PAN:    pan_q[sel_q]       <= reg_data_i;
              REG_FRQ_LO: frq_q[sel_q][7:0]  <= reg_data_i;
              REG_FRQ_HI: frq_q[sel_q][15:8] <= reg_data_i;
              REG_LP_LO:  lp_q[sel_q][7:0]   <= reg_data_i;
              REG_LP_HI:  lp_q[sel_q][15:8]  <= reg_data_i;
              REG_START:  st_q[sel_q]        <= reg_data_i;
              default:    ;
            endcase
          end
        end else if (reg_addr_i == REG_CTRL) begin
          if (reg_data_i[6]) begin
            sel_q <= reg_data_i[2:0];
          end else begin
            bank_q <= reg_data_i[3:0];
          end
          ctl_q <= reg_data_i;
        end else if (reg_addr_i == REG_ENABLE) begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (!en_q[c]) begin
              posa_q[c] <= PW'({st_q[c], {(FRAC_BITS + 8){1'b0}}});
            end
          end
          en_q <= ~reg_data_i;
        end
      end
      if (cmd_i.store_pos) begin
        posa_q[ch_q] <= cmd_i.store_loop ? loop_pos : pos_q;
      end
    end
  end

  // per-tick working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q   <= '0;
      oval_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        ch_q <= '0;
      end else if (cmd_i.ch_inc) begin
        ch_q <= ch_q + 3'd1;
      end
      if (cmd_i.out_ld) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      accl_q <= '0;
      accr_q <= '0;
    end
    if (cmd_i.ld_ch) begin
      pos_q  <= posa_q[ch_q];
      step_q <= step_full[STEP_SHIFT +: 19];
      ml_q   <= (!stereo_q && gl < gr) ? gr : gl;
      mr_q   <= gr;
    end
    if (cmd_i.set_loop) begin
      pos_q <= loop_pos;
    end
    if (cmd_i.mix) begin
      accl_q <= accl_q + addl;
      accr_q <= accr_q + addr_r;
      k_q    <= {1'b0, pos_q[PW-1:FRAC_BITS]} + (A + 1)'(1);
      pos_q  <= new_pos;
      kend_q <= new_pos[PW-1:FRAC_BITS];
    end
    if (cmd_i.k_inc) begin
      k_q <= k_q + (A + 1)'(1);
    end
    if (cmd_i.out_ld) begin
      outl_q <= accl_q;
      outr_q <= stereo_q ? accr_q : '0;
    end
  end

  assign out_valid_o = oval_q;
  assign left_o      = outl_q;
  assign right_o     = outr_q;

endmodule

/* hw/rtl/epcm_ctrl.sv */
module epcm_ctrl import epcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_cmd_i == CMD_TICK) state_d = ST_CH;
      end
      ST_CH: begin
        if (sts_i.ch_on) state_d = ST_RD0;
        else if (sts_i.last_ch) state_d = ST_DONE;
      end
      ST_RD0: state_d = sts_i.mark ? ST_RD1 : ST_SCAN_RD;
      ST_RD1: begin
        if (!sts_i.mark) state_d = ST_SCAN_RD;
        else state_d = sts_i.last_ch ? ST_DONE : ST_CH;
      end
      ST_SCAN_RD:  state_d = sts_i.scan_more ? ST_SCAN_CHK : ST_FIN_RD;
      ST_SCAN_CHK: state_d = sts_i.mark ? ST_FIN_RD : ST_SCAN_RD;
      ST_FIN_RD:   state_d = ST_FIN_CHK;
      ST_FIN_CHK:  state_d = sts_i.last_ch ? ST_DONE : ST_CH;
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = RD_POS;
    case (state_q)
      ST_IDLE: begin
        cmd_o.clr = in_valid_i && in_cmd_i == CMD_TICK;
      end
      ST_CH: begin
        cmd_o.ld_ch  = sts_i.ch_on;
        cmd_o.rd_en  = sts_i.ch_on;
        cmd_o.rd_sel = RD_ENTRY;
        cmd_o.ch_inc = !sts_i.ch_on && !sts_i.last_ch;
      end
      ST_RD0: begin
        cmd_o.mix      = !sts_i.mark;
        cmd_o.set_loop = sts_i.mark;
        cmd_o.rd_en    = sts_i.mark;
        cmd_o.rd_sel   = RD_LOOP;
      end
      ST_RD1: begin
        cmd_o.mix       = !sts_i.mark;
        cmd_o.store_pos = sts_i.mark;
        cmd_o.ch_inc    = sts_i.mark && !sts_i.last_ch;
      end
      ST_SCAN_RD: begin
        cmd_o.rd_en  = sts_i.scan_more;
        cmd_o.rd_sel = RD_K;
      end
      ST_SCAN_CHK: begin
        cmd_o.set_loop = sts_i.mark;
        cmd_o.k_inc    = !sts_i.mark;
      end
      ST_FIN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_POS;
      end
      ST_FIN_CHK: begin
        cmd_o.store_pos  = 1'b1;
        cmd_o.store_loop = sts_i.mark;
        cmd_o.ch_inc     = !sts_i.last_ch;
      end
      ST_DONE: begin
        cmd_o.out_ld = sts_i.out_free;
      end
      default: ;
    endcase
  end

  // a marker byte never gets mixed
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.mix |-> !sts_i.mark)
    else $error("mix on loop marker");
  // an exhausted scan always goes to the final position check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_RD && !sts_i.scan_more) |=> state_q == ST_FIN_RD)
    else $error("scan exit lost");
  // loading the result ends the tick
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.out_ld |=> state_q == ST_IDLE)
    else $error("result load outside tick end");

endmodule

/* hw/rtl/eight_channel_pcm_sample_player.sv */
// Channel | Dir | Handshake                   | Payload
// s_axis  | in  | s_axis_tvalid/s_axis_tready | cmd, reg_addr, reg_data, mem_addr, mem_data
// m_axis  | out | m_axis_tvalid/m_axis_tready | left_sample, right_sample
// cfg     | in  | cfg_we_i (no ready)         | cfg_addr_i index, cfg_data_i value
//
// A tick walks the channels and skips those that are off. An enabled one reads
// its entry byte; a marker jumps to the loop target, a second one silences it.
// Else the byte is mixed, bytes up to the new position are scanned for markers
// and the final byte is read, all on the single wave memory read port. Reset
// clears control and registers, not the wave memory. A waiting result does not
// block input; only the end of the next tick waits for a free output register.
module eight_channel_pcm_sample_player import epcm_pkg::*; #(
  parameter int FRAC_BITS      = 11,
  parameter int CHANNELS       = 8,
  parameter int WAVE_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [5:2] reg_addr, [13:6] reg_data, [29:14] mem_addr, [37:30] mem_data
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [16:0] left_sample, [33:17] right_sample
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [16:0] cfg_data_i
);

  cmd_t        cmd;
  sts_t        sts;
  logic [16:0] left, right;

  epcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tdata[1:0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  epcm_dp #(
    .FRAC_BITS      (FRAC_BITS),
    .CHANNELS       (CHANNELS),
    .WAVE_ADDR_BITS (WAVE_ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s_axis_tvalid && s_axis_tready),
    .in_cmd_i    (s_axis_tdata[1:0]),
    .reg_addr_i  (s_axis_tdata[5:2]),
    .reg_data_i  (s_axis_tdata[13:6]),
    .mem_addr_i  (s_axis_tdata[29:14]),
    .mem_data_i  (s_axis_tdata[37:30]),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .left_o      (left),
    .right_o     (right)
  );

  assign m_axis_tdata = {6'b0, right, left};

endmodule
